[sv/utf8_decode_with_replacement_macros.svh]
// Assertion macros for the UTF-8 decoder block.
// Used by the RTL files that carry assertions; empty when SYNTHESIS is defined.
`ifndef UTF8_DECODE_WITH_REPLACEMENT_MACROS_SVH
`define UTF8_DECODE_WITH_REPLACEMENT_MACROS_SVH

`ifndef SYNTHESIS

`define UDR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define UDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define UDR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define UDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/utf8d_pkg.sv]
// Package for the UTF-8 decoder: widths, byte-class constants, result type
// and counter helpers. No dependencies.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int MAX_LIST_BYTES = 4096;
    localparam int POS_W          = $clog2(MAX_LIST_BYTES + 2);
    localparam int CP_W           = 21;
    localparam int OFF_W          = 12;
    localparam int CNT_W          = 13;
    localparam int OFFSET_CAP     = 4095;
    localparam int COUNT_CAP      = 4096;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;
    localparam logic [CP_W-1:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_TAB    = 21'd9;
    localparam logic [CP_W-1:0] CP_LF     = 21'd10;
    localparam logic [CP_W-1:0] CP_CR     = 21'd13;
    localparam logic [CP_W-1:0] CP_SPACE  = 21'd32;
    localparam logic [CP_W-1:0] CP_TILDE  = 21'd126;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_SUR = 8'hED;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [OFF_W-1:0] start_offset;
        logic             is_replacement;
        logic             run_last;
        logic             list_done;
        logic [CNT_W-1:0] units_total;
        logic [CNT_W-1:0] printable_total;
        logic             mostly_printable;
        logic             too_long;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] units;
        logic [CNT_W-1:0] printable;
    } counts_t;

    typedef struct packed {
        logic not_empty;
        logic room_two;
    } fifo_status_t;

    function automatic logic [CP_W-1:0] map_nul(input logic [CP_W-1:0] cp);
        return (cp == '0) ? CP_LF : cp;
    endfunction

    function automatic logic [OFF_W-1:0] sat_offset(input logic [POS_W-1:0] p);
        return (32'(p) > OFFSET_CAP) ? OFF_W'(OFFSET_CAP) : OFF_W'(p);
    endfunction

    function automatic counts_t count_step(input logic [CP_W-1:0] cp, input counts_t c);
        logic [CNT_W:0] u_sum;
        logic           printable;
        counts_t        r;
        u_sum = {1'b0, c.units} + ((cp > BMP_MAX) ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
        r.units = (u_sum > (CNT_W+1)'(COUNT_CAP)) ? CNT_W'(COUNT_CAP) : u_sum[CNT_W-1:0];
        printable = (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
                    ((cp >= CP_SPACE) && (cp <= CP_TILDE));
        r.printable = (printable && (c.printable < CNT_W'(COUNT_CAP))) ?
                      c.printable + 1'b1 : c.printable;
        return r;
    endfunction

endpackage

[sv/utf8d_result_fifo.sv]
// Small result queue for the UTF-8 decoder; takes up to two results per cycle.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_result_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              push_cnt,
    input  utf8d_pkg::result_t      push_data0,
    input  utf8d_pkg::result_t      push_data1,
    input  logic                    pop,
    output utf8d_pkg::result_t      head,
    output utf8d_pkg::fifo_status_t status
);

    utf8d_pkg::result_t mem_reg [utf8d_pkg::FIFO_DEPTH];

    logic [utf8d_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [utf8d_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [utf8d_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [utf8d_pkg::FIFO_PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + utf8d_pkg::FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + utf8d_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + utf8d_pkg::FIFO_CNT_W'(push_cnt)
                    - utf8d_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push_data1;
        end
    end

    assign head             = mem_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.room_two  = (count_reg <= utf8d_pkg::FIFO_CNT_W'(utf8d_pkg::FIFO_DEPTH - 2));

endmodule

[sv/utf8_decode_with_replacement.sv]
// Top level of the strict UTF-8 decoder with replacement and text statistics.
// Depends on utf8d_pkg, utf8d_result_fifo and utf8_decode_with_replacement_macros.svh.
`timescale 1ns / 1ps

// Input channel: one byte per transaction (data_byte, end_of_input marks the
// last byte of a list). Output channel: one decoded code point per transaction
// with its start offset, running UTF-16 unit and printable counts, and on the
// list's final result the mostly_printable and too_long flags.
// A byte yields zero, one or two results; a lead byte that opens a sequence
// yields none until the sequence completes or breaks.
// A result passes through the input register and the result queue before it is
// offered. Throughput: one byte per cycle while the queue has room. The decode step
// between the input register and the four-entry result queue fires when the queue
// has two free slots, so the output side (one result per cycle) sets the sustained
// rate, and a byte that yields two results uses the output side twice.
// Reset clears the decoder state and the queue; after the last byte of a
// list the decoder state returns to reset so the next list starts at offset 0.
// When the receiver stalls, results wait in the queue; once fewer than two
// slots are free a byte in the input register holds and in_stall is raised.

`include "utf8_decode_with_replacement_macros.svh"

module utf8_decode_with_replacement
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_input,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [utf8d_pkg::CP_W-1:0]   code_point,
    output logic [utf8d_pkg::OFF_W-1:0]  start_offset,
    output logic                         is_replacement,
    output logic                         run_last,
    output logic                         list_done,
    output logic [utf8d_pkg::CNT_W-1:0]  units_total,
    output logic [utf8d_pkg::CNT_W-1:0]  printable_total,
    output logic                         mostly_printable,
    output logic                         too_long
);

    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0]  cp;
        logic [utf8d_pkg::OFF_W-1:0] off;
        logic                        repl;
    } emit_t;

    // input register
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;

    // decoder state
    logic [utf8d_pkg::CP_W-1:0]  partial_reg, partial_mid;
    logic [1:0]                  need_reg, need_mid;
    logic                        pend_reg, pend_mid;
    logic [7:0]                  lo_reg, lo_mid;
    logic [7:0]                  hi_reg, hi_mid;
    logic [utf8d_pkg::OFF_W-1:0] start_reg, start_mid;
    logic [utf8d_pkg::POS_W-1:0] pos_reg, pos_next;
    utf8d_pkg::counts_t          cnt_reg, cnt_next;

    logic                        accept, fire;
    logic [7:0]                  b;
    logic [7:0]                  lo_eff, hi_eff;
    logic                        open_cur, cont_ok, broken, cont_done;
    logic [utf8d_pkg::CP_W-1:0]  partial_shift;
    logic [utf8d_pkg::OFF_W-1:0] cur_off;
    logic                        lead_ascii, lead_2, lead_3, lead_4, lead_emits;
    logic                        trunc;
    emit_t                       c1, c2, c3, slot0, slot1;
    logic [1:0]                  n_emit, push_cnt;
    utf8d_pkg::counts_t          cnt0, cnt1, cnt_final;
    logic                        ratio_ok, long_list;
    utf8d_pkg::result_t          res0, res1, head;
    utf8d_pkg::fifo_status_t     fstat;

    assign accept   = in_valid && !in_stall;
    assign fire     = stage_valid_reg && fstat.room_two;
    assign in_stall = stage_valid_reg && !fstat.room_two;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= data_byte;
            stage_last_reg <= end_of_input;
        end
    end

    // byte classification
    assign b             = stage_byte_reg;
    assign open_cur      = (need_reg != 2'd0);
    assign lo_eff        = pend_reg ? lo_reg : utf8d_pkg::CONT_LO;
    assign hi_eff        = pend_reg ? hi_reg : utf8d_pkg::CONT_HI;
    assign cont_ok       = open_cur && (b >= lo_eff) && (b <= hi_eff);
    assign broken        = open_cur && !cont_ok;
    assign cont_done     = cont_ok && (need_reg == 2'd1);
    assign partial_shift = {partial_reg[utf8d_pkg::CP_W-7:0], b[5:0]};
    assign cur_off       = utf8d_pkg::sat_offset(pos_reg);

    assign lead_ascii = (b <= utf8d_pkg::ASCII_MAX);
    assign lead_2     = (b >= utf8d_pkg::LEAD2_LO) && (b <= utf8d_pkg::LEAD2_HI);
    assign lead_3     = (b >= utf8d_pkg::LEAD3_LO) && (b <= utf8d_pkg::LEAD3_HI);
    assign lead_4     = (b >= utf8d_pkg::LEAD4_LO) && (b <= utf8d_pkg::LEAD4_HI);
    assign lead_emits = !cont_ok && !(lead_2 || lead_3 || lead_4);

    always_comb
    begin
        partial_mid = partial_reg;
        need_mid    = need_reg;
        pend_mid    = pend_reg;
        lo_mid      = lo_reg;
        hi_mid      = hi_reg;
        start_mid   = start_reg;
        if (cont_ok)
        begin
            partial_mid = partial_shift;
            need_mid    = need_reg - 2'd1;
            pend_mid    = 1'b0;
        end
        else
        begin
            need_mid = 2'd0;
            pend_mid = 1'b0;
            if (lead_2)
            begin
                need_mid    = 2'd1;
                partial_mid = utf8d_pkg::CP_W'(b[4:0]);
                pend_mid    = 1'b1;
                lo_mid      = utf8d_pkg::CONT_LO;
                hi_mid      = utf8d_pkg::CONT_HI;
                start_mid   = cur_off;
            end
            else if (lead_3)
            begin
                need_mid    = 2'd2;
                partial_mid = utf8d_pkg::CP_W'(b[3:0]);
                pend_mid    = 1'b1;
                lo_mid      = (b == utf8d_pkg::LEAD3_LO) ? utf8d_pkg::E0_LO : utf8d_pkg::CONT_LO;
                hi_mid      = (b == utf8d_pkg::LEAD3_SUR) ? utf8d_pkg::ED_HI : utf8d_pkg::CONT_HI;
                start_mid   = cur_off;
            end
            else if (lead_4)
            begin
                need_mid    = 2'd3;
                partial_mid = utf8d_pkg::CP_W'(b[2:0]);
                pend_mid    = 1'b1;
                lo_mid      = (b == utf8d_pkg::LEAD4_LO) ? utf8d_pkg::F0_LO : utf8d_pkg::CONT_LO;
                hi_mid      = (b == utf8d_pkg::LEAD4_HI) ? utf8d_pkg::F4_HI : utf8d_pkg::CONT_HI;
                start_mid   = cur_off;
            end
        end
    end

    assign trunc = stage_last_reg && (need_mid != 2'd0);

    // candidate results in order: continuation stage, lead byte, truncated tail
    always_comb
    begin
        c1.cp   = utf8d_pkg::map_nul(cont_done ? partial_shift : utf8d_pkg::REPL_CHAR);
        c1.off  = start_reg;
        c1.repl = broken;
        c2.cp   = utf8d_pkg::map_nul(lead_ascii ? utf8d_pkg::CP_W'(b) : utf8d_pkg::REPL_CHAR);
        c2.off  = cur_off;
        c2.repl = !lead_ascii;
        c3.cp   = utf8d_pkg::REPL_CHAR;
        c3.off  = start_mid;
        c3.repl = 1'b1;

        slot0 = (cont_done || broken) ? c1 : (lead_emits ? c2 : c3);
        slot1 = (cont_done || broken) ? (lead_emits ? c2 : c3) : c3;
        n_emit = 2'(cont_done || broken) + 2'(lead_emits) + 2'(trunc);
    end

    assign cnt0      = utf8d_pkg::count_step(slot0.cp, cnt_reg);
    assign cnt1      = utf8d_pkg::count_step(slot1.cp, cnt0);
    assign cnt_final = (n_emit == 2'd2) ? cnt1 : ((n_emit == 2'd1) ? cnt0 : cnt_reg);

    assign ratio_ok  = (cnt_final.units != '0) &&
                       (({2'b00, cnt_final.printable} << 2) >=
                        ({2'b00, cnt_final.units} + ({2'b00, cnt_final.units} << 1)));
    assign long_list = (32'(pos_reg) >= utf8d_pkg::MAX_LIST_BYTES);

    always_comb
    begin
        res0.code_point       = slot0.cp;
        res0.start_offset     = slot0.off;
        res0.is_replacement   = slot0.repl;
        res0.run_last         = (n_emit == 2'd1);
        res0.list_done        = stage_last_reg && (n_emit == 2'd1);
        res0.units_total      = cnt0.units;
        res0.printable_total  = cnt0.printable;
        res0.mostly_printable = res0.list_done && ratio_ok;
        res0.too_long         = res0.list_done && long_list;

        res1.code_point       = slot1.cp;
        res1.start_offset     = slot1.off;
        res1.is_replacement   = slot1.repl;
        res1.run_last         = 1'b1;
        res1.list_done        = stage_last_reg;
        res1.units_total      = cnt1.units;
        res1.printable_total  = cnt1.printable;
        res1.mostly_printable = stage_last_reg && ratio_ok;
        res1.too_long         = stage_last_reg && long_list;
    end

    assign push_cnt = fire ? n_emit : 2'd0;
    assign pos_next = (32'(pos_reg) <= utf8d_pkg::MAX_LIST_BYTES) ? pos_reg + 1'b1 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            need_reg    <= 2'd0;
            pend_reg    <= 1'b0;
            lo_reg      <= utf8d_pkg::CONT_LO;
            hi_reg      <= utf8d_pkg::CONT_HI;
            start_reg   <= '0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
        end
        else if (fire)
        begin
            if (stage_last_reg)
            begin
                partial_reg <= '0;
                need_reg    <= 2'd0;
                pend_reg    <= 1'b0;
                lo_reg      <= utf8d_pkg::CONT_LO;
                hi_reg      <= utf8d_pkg::CONT_HI;
                start_reg   <= '0;
                pos_reg     <= '0;
                cnt_reg     <= '0;
            end
            else
            begin
                partial_reg <= partial_mid;
                need_reg    <= need_mid;
                pend_reg    <= pend_mid;
                lo_reg      <= lo_mid;
                hi_reg      <= hi_mid;
                start_reg   <= start_mid;
                pos_reg     <= pos_next;
                cnt_reg     <= cnt_final;
            end
        end
    end

    utf8d_result_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data0 (res0),
        .push_data1 (res1),
        .pop        (out_valid && !out_stall),
        .head       (head),
        .status     (fstat)
    );

    assign out_valid        = fstat.not_empty;
    assign code_point       = head.code_point;
    assign start_offset     = head.start_offset;
    assign is_replacement   = head.is_replacement;
    assign run_last         = head.run_last;
    assign list_done        = head.list_done;
    assign units_total      = head.units_total;
    assign printable_total  = head.printable_total;
    assign mostly_printable = head.mostly_printable;
    assign too_long         = head.too_long;

    `UDR_ASSERT_NEXT(a_clear_after_last, clk, rst_n, fire && stage_last_reg, need_reg == 2'd0 && pos_reg == '0 && cnt_reg == '0)
    `UDR_ASSERT_IMPLIES(a_last_yields, clk, rst_n, fire && stage_last_reg, push_cnt != 2'd0)
    `UDR_ASSERT_IMPLIES(a_pend_needs_open, clk, rst_n, pend_reg, need_reg != 2'd0)
    `UDR_ASSERT_IMPLIES(a_repl_value, clk, rst_n, out_valid && is_replacement, code_point == utf8d_pkg::REPL_CHAR)
    `UDR_ASSERT_IMPLIES(a_done_is_run_last, clk, rst_n, out_valid && list_done, run_last)

endmodule
